### hdl/gif_lzw_pixel_decoder_assert.svh
// ----------------------------------------------------------------------------
// GIF LZW pixel decoder assertion macros
// Shared shorthand for the concurrent checks of the decoder.
// ----------------------------------------------------------------------------
`ifndef GIF_LZW_PIXEL_DECODER_ASSERT_SVH
`define GIF_LZW_PIXEL_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GLPD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GLPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/glpd_pkg.sv
// ----------------------------------------------------------------------------
// GIF LZW pixel decoder package
// Operation, status and phase codes and the default sizes of the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package glpd_pkg;
	localparam int GLPD_MAX_CODE_BITS = 12;
	localparam int GLPD_DICT_DEPTH    = 4096;
	localparam int GLPD_PALETTE_DEPTH = 256;
	localparam int GLPD_ACC_BITS      = 32;

	localparam int OP_W     = 2;
	localparam int STATUS_W = 3;
	localparam int PHASE_W  = 3;
	localparam int CW_W     = 4;
	localparam int IN_W     = 48;
	localparam int OUT_W    = 32;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [PHASE_W-1:0]  phase_t;

	localparam op_t OP_PUSH    = 2'd0;
	localparam op_t OP_PULL    = 2'd1;
	localparam op_t OP_PALETTE = 2'd2;
	localparam op_t OP_START   = 2'd3;

	localparam status_t STAT_ACCEPTED = 3'd0;
	localparam status_t STAT_PIXEL    = 3'd1;
	localparam status_t STAT_NEED     = 3'd2;
	localparam status_t STAT_END      = 3'd3;
	localparam status_t STAT_REFUSED  = 3'd4;
	localparam status_t STAT_BAD      = 3'd5;

	localparam phase_t PH_IDLE    = 3'd0;
	localparam phase_t PH_DECODE  = 3'd1;
	localparam phase_t PH_DRAINED = 3'd2;
	localparam phase_t PH_ENDED   = 3'd3;
	localparam phase_t PH_BAD     = 3'd4;
endpackage

### hdl/glpd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module glpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### hdl/gif_lzw_pixel_decoder.sv
// ----------------------------------------------------------------------------
// GIF LZW pixel decoder
// Unpacks GIF image data and returns at most one palette colour per pull request.
// ----------------------------------------------------------------------------
// The block takes one transfer at a time and answers each with exactly one
// result transfer. Push, palette write and start go straight to the response
// state. A pull that finds pixels on the stack passes through the registered
// reads of the pixel stack and the palette memory in turn. A pull that has to
// decode a code takes the code, walks the dictionary links one at a time,
// because every link is a read of the dictionary memory whose prefix addresses
// the next read, and then pushes the final literal. Every clear code met on
// the way is handled in the pull state before the next code is taken. The
// memories need no clearing pass after reset.
`timescale 1ns / 1ps
module gif_lzw_pixel_decoder #(
	parameter int MAX_CODE_BITS = glpd_pkg::GLPD_MAX_CODE_BITS,
	parameter int DICT_DEPTH    = glpd_pkg::GLPD_DICT_DEPTH,
	parameter int PALETTE_DEPTH = glpd_pkg::GLPD_PALETTE_DEPTH,
	parameter int ACC_BITS      = glpd_pkg::GLPD_ACC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// data_byte, min_code_size, palette_index, red_in, green_in, blue_in, zero fill
	input  logic [glpd_pkg::IN_W-1:0]     s_tdata,
	// operation
	input  logic [glpd_pkg::OP_W-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// color_index, red_out, green_out, blue_out
	output logic [glpd_pkg::OUT_W-1:0]    m_tdata,
	// status
	output logic [glpd_pkg::STATUS_W-1:0] m_tuser
);
	import glpd_pkg::*;
	`include "gif_lzw_pixel_decoder_assert.svh"

	localparam int AW_D = $clog2(DICT_DEPTH);
	localparam int SC_W = AW_D + 1;
	localparam int NF_W = MAX_CODE_BITS + 1;
	localparam int XW   = ((AW_D > MAX_CODE_BITS) ? AW_D : MAX_CODE_BITS) + 2;
	localparam int PA_W = $clog2(PALETTE_DEPTH);
	localparam int BH_W = $clog2(ACC_BITS + 1);
	localparam int DW   = MAX_CODE_BITS + 8;
	localparam int DLIM = (DICT_DEPTH < (1 << MAX_CODE_BITS)) ? DICT_DEPTH
		: (1 << MAX_CODE_BITS);

	localparam logic [2:0] ST_IDLE       = 3'd0;
	localparam logic [2:0] ST_PULL       = 3'd1;
	localparam logic [2:0] ST_CHAIN      = 3'd2;
	localparam logic [2:0] ST_CHAIN_WAIT = 3'd3;
	localparam logic [2:0] ST_POP1       = 3'd4;
	localparam logic [2:0] ST_POP2       = 3'd5;
	localparam logic [2:0] ST_RESP       = 3'd6;

	localparam logic [3:0] A_POP   = 4'd0;
	localparam logic [3:0] A_IDLE  = 4'd1;
	localparam logic [3:0] A_ENDED = 4'd2;
	localparam logic [3:0] A_BAD   = 4'd3;
	localparam logic [3:0] A_SHORT = 4'd4;
	localparam logic [3:0] A_CLEAR = 4'd5;
	localparam logic [3:0] A_EOI   = 4'd6;
	localparam logic [3:0] A_LIT   = 4'd7;
	localparam logic [3:0] A_ADD   = 4'd8;
	localparam logic [3:0] A_KWK   = 4'd9;

	logic [2:0]               state_q;
	phase_t                   phase_q;
	logic [ACC_BITS-1:0]      acc_q;
	logic [BH_W-1:0]          bh_q;
	logic [CW_W-1:0]          cw_q;
	logic [CW_W-1:0]          root_q;
	logic [NF_W-1:0]          nfc_q;
	logic [MAX_CODE_BITS-1:0] prev_code_q;
	logic [7:0]               prev_first_q;
	logic                     have_prev_q;
	logic [7:0]               sub_q;
	logic [SC_W-1:0]          sc_q;
	logic [MAX_CODE_BITS-1:0] c_q;
	logic [MAX_CODE_BITS-1:0] code_q;
	logic                     add_q;
	logic [7:0]               pix_idx_q;
	logic [PALETTE_DEPTH-1:0] pal_vld_q;
	status_t                  resp_status_q;
	logic [OUT_W-1:0]         resp_data_q;
	logic                     m_tvalid_q;
	status_t                  m_tuser_q;
	logic [OUT_W-1:0]         m_tdata_q;

	op_t                      in_op;
	logic [7:0]               in_byte;
	logic [3:0]               in_mcs;
	logic [7:0]               in_pidx;
	logic [CW_W-1:0]          root_new;
	logic [MAX_CODE_BITS-1:0] code_w;
	logic [MAX_CODE_BITS-1:0] clear_w;
	logic [NF_W-1:0]          nfc_inc;
	logic                     can_add;
	logic                     grow;
	logic                     chain_go;
	logic [3:0]               act;
	logic                     out_free;
	logic [23:0]              rgb;
	logic                     push_full;
	logic                     push_refused;

	logic                     dict_we;
	logic [DW-1:0]            dict_wdata;
	logic                     dict_re;
	logic [DW-1:0]            dict_rdata;
	logic                     stk_we;
	logic [7:0]               stk_wdata;
	logic                     stk_re;
	logic [7:0]               stk_rdata;
	logic                     pal_we;
	logic                     pal_re;
	logic [23:0]              pal_rdata;

	assign in_op    = s_tuser;
	assign in_byte  = s_tdata[7:0];
	assign in_mcs   = s_tdata[11:8];
	assign in_pidx  = s_tdata[19:12];
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

	assign root_new = (in_mcs < 4'd2) ? CW_W'(2) : ((in_mcs > 4'd8) ? CW_W'(8) : in_mcs);
	assign code_w   = acc_q[MAX_CODE_BITS-1:0] & ~({MAX_CODE_BITS{1'b1}} << cw_q);
	assign clear_w  = MAX_CODE_BITS'(1) << root_q;
	assign nfc_inc  = nfc_q + NF_W'(1);
	assign can_add  = nfc_q < NF_W'(DLIM);
	assign grow     = (nfc_inc == (NF_W'(1) << cw_q)) && (cw_q < CW_W'(MAX_CODE_BITS));
	assign chain_go = (XW'(c_q) >= XW'(clear_w) + XW'(2)) && (XW'(c_q) < XW'(DICT_DEPTH))
		&& (sc_q < SC_W'(DICT_DEPTH - 1));
	assign rgb      = (({1'b0, pix_idx_q} < 9'(PALETTE_DEPTH)) && pal_vld_q[PA_W'(pix_idx_q)])
		? pal_rdata : 24'd0;
	assign push_full    = ((BH_W + 1)'(bh_q) + (BH_W + 1)'(8)) > (BH_W + 1)'(ACC_BITS);
	assign push_refused = (phase_q == PH_IDLE) || (phase_q == PH_DRAINED)
		|| ((phase_q == PH_DECODE) && (sub_q != 8'd0) && push_full);

	always_comb begin
		priority if (sc_q != '0) begin
			act = A_POP;
		end else if (phase_q == PH_IDLE) begin
			act = A_IDLE;
		end else if (phase_q == PH_ENDED) begin
			act = A_ENDED;
		end else if (phase_q == PH_BAD) begin
			act = A_BAD;
		end else if (bh_q < BH_W'(cw_q)) begin
			act = A_SHORT;
		end else if (code_w == clear_w) begin
			act = A_CLEAR;
		end else if (code_w == clear_w + MAX_CODE_BITS'(1)) begin
			act = A_EOI;
		end else if (!have_prev_q) begin
			act = (code_w >= clear_w) ? A_BAD : A_LIT;
		end else if (NF_W'(code_w) < nfc_q) begin
			act = A_ADD;
		end else if ((NF_W'(code_w) == nfc_q) && can_add) begin
			act = A_KWK;
		end else begin
			act = A_BAD;
		end
	end

	always_comb begin
		dict_we    = 1'b0;
		dict_wdata = {prev_code_q, prev_first_q};
		if (state_q == ST_PULL && act == A_KWK) begin
			dict_we = 1'b1;
		end else if (state_q == ST_CHAIN && !chain_go && add_q && can_add) begin
			dict_we    = 1'b1;
			dict_wdata = {prev_code_q, c_q[7:0]};
		end
		dict_re   = (state_q == ST_CHAIN) && chain_go;
		stk_we    = (state_q == ST_CHAIN_WAIT)
			|| ((state_q == ST_CHAIN) && !chain_go && (sc_q < SC_W'(DICT_DEPTH)));
		stk_wdata = (state_q == ST_CHAIN_WAIT) ? dict_rdata[7:0] : c_q[7:0];
		stk_re    = (state_q == ST_PULL) && (act == A_POP);
		pal_we    = s_tvalid && s_tready && (in_op == OP_PALETTE)
			&& ({1'b0, in_pidx} < 9'(PALETTE_DEPTH));
		pal_re    = (state_q == ST_POP1);
	end

	glpd_ram #(.WIDTH(DW), .DEPTH(DICT_DEPTH)) u_dict (
		.clk   (clk),
		.we    (dict_we),
		.waddr (AW_D'(nfc_q)),
		.wdata (dict_wdata),
		.re    (dict_re),
		.raddr (AW_D'(c_q)),
		.rdata (dict_rdata)
	);

	glpd_ram #(.WIDTH(8), .DEPTH(DICT_DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (AW_D'(sc_q)),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (AW_D'(sc_q - SC_W'(1))),
		.rdata (stk_rdata)
	);

	glpd_ram #(.WIDTH(24), .DEPTH(PALETTE_DEPTH)) u_palette (
		.clk   (clk),
		.we    (pal_we),
		.waddr (PA_W'(in_pidx)),
		.wdata (s_tdata[43:20] & 24'hFFFFFF),
		.re    (pal_re),
		.raddr (PA_W'(stk_rdata)),
		.rdata (pal_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			phase_q       <= PH_IDLE;
			acc_q         <= '0;
			bh_q          <= '0;
			cw_q          <= CW_W'(9);
			root_q        <= CW_W'(8);
			nfc_q         <= NF_W'(258);
			prev_code_q   <= '0;
			prev_first_q  <= '0;
			have_prev_q   <= 1'b0;
			sub_q         <= '0;
			sc_q          <= '0;
			add_q         <= 1'b0;
			pal_vld_q     <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (state_q == ST_RESP && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (pal_we) begin
				pal_vld_q[PA_W'(in_pidx)] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					resp_data_q   <= '0;
					resp_status_q <= (in_op == OP_PUSH && push_refused) ? STAT_REFUSED
						: STAT_ACCEPTED;
					if (s_tvalid) begin
						state_q <= (in_op == OP_PULL) ? ST_PULL : ST_RESP;
						unique case (in_op)
							OP_PUSH: begin
								if (phase_q == PH_DECODE) begin
									if (sub_q == 8'd0) begin
										if (in_byte == 8'd0) begin
											phase_q <= PH_DRAINED;
										end else begin
											sub_q <= in_byte;
										end
									end else if (!push_full) begin
										acc_q <= acc_q | (ACC_BITS'(in_byte) << bh_q);
										bh_q  <= bh_q + BH_W'(8);
										sub_q <= sub_q - 8'd1;
									end
								end
							end
							OP_PULL: begin
							end
							OP_PALETTE: begin
							end
							OP_START: begin
								root_q       <= root_new;
								cw_q         <= root_new + CW_W'(1);
								nfc_q        <= (NF_W'(1) << root_new) + NF_W'(2);
								have_prev_q  <= 1'b0;
								sc_q         <= '0;
								acc_q        <= '0;
								bh_q         <= '0;
								sub_q        <= '0;
								prev_code_q  <= '0;
								prev_first_q <= '0;
								phase_q      <= PH_DECODE;
							end
							default: begin
							end
						endcase
					end
				end
				ST_PULL: begin
					resp_data_q <= '0;
					if (act != A_POP && act != A_IDLE && act != A_ENDED && act != A_BAD
						&& act != A_SHORT) begin
						acc_q <= acc_q >> cw_q;
						bh_q  <= bh_q - BH_W'(cw_q);
					end
					unique case (act)
						A_POP: begin
							sc_q    <= sc_q - SC_W'(1);
							state_q <= ST_POP1;
						end
						A_IDLE: begin
							resp_status_q <= STAT_REFUSED;
							state_q       <= ST_RESP;
						end
						A_ENDED, A_EOI: begin
							phase_q       <= PH_ENDED;
							resp_status_q <= STAT_END;
							state_q       <= ST_RESP;
						end
						A_BAD: begin
							phase_q       <= PH_BAD;
							resp_status_q <= STAT_BAD;
							state_q       <= ST_RESP;
						end
						A_SHORT: begin
							if (phase_q == PH_DRAINED) begin
								phase_q       <= PH_ENDED;
								resp_status_q <= STAT_END;
							end else begin
								resp_status_q <= STAT_NEED;
							end
							state_q <= ST_RESP;
						end
						A_CLEAR: begin
							cw_q        <= root_q + CW_W'(1);
							nfc_q       <= NF_W'(clear_w) + NF_W'(2);
							have_prev_q <= 1'b0;
						end
						A_LIT, A_ADD, A_KWK: begin
							c_q         <= code_w;
							code_q      <= code_w;
							add_q       <= (act == A_ADD);
							have_prev_q <= 1'b1;
							state_q     <= ST_CHAIN;
							if (act == A_KWK) begin
								nfc_q <= nfc_inc;
								if (grow) begin
									cw_q <= cw_q + CW_W'(1);
								end
							end
						end
						default: begin
							state_q <= ST_PULL;
						end
					endcase
				end
				ST_CHAIN: begin
					if (chain_go) begin
						state_q <= ST_CHAIN_WAIT;
					end else begin
						if (sc_q < SC_W'(DICT_DEPTH)) begin
							sc_q <= sc_q + SC_W'(1);
						end
						if (add_q && can_add) begin
							nfc_q <= nfc_inc;
							if (grow) begin
								cw_q <= cw_q + CW_W'(1);
							end
						end
						prev_code_q  <= code_q;
						prev_first_q <= c_q[7:0];
						state_q      <= ST_PULL;
					end
				end
				ST_CHAIN_WAIT: begin
					sc_q    <= sc_q + SC_W'(1);
					c_q     <= dict_rdata[DW-1:8];
					state_q <= ST_CHAIN;
				end
				ST_POP1: begin
					pix_idx_q <= stk_rdata;
					state_q   <= ST_POP2;
				end
				ST_POP2: begin
					resp_status_q <= STAT_PIXEL;
					resp_data_q   <= {rgb[23:16], rgb[15:8], rgb[7:0], pix_idx_q};
					state_q       <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && out_free) begin
			m_tuser_q <= resp_status_q;
			m_tdata_q <= resp_data_q;
		end
	end

	`GLPD_ASSERT_NOW(a_stack_bound, 1'b1, sc_q <= SC_W'(DICT_DEPTH), "Pixel stack overrun.")
	`GLPD_ASSERT_NEXT(a_chain_read, dict_re, state_q == ST_CHAIN_WAIT, "Chain read lost.")
	`GLPD_ASSERT_NOW(a_table_bound, 1'b1,
		cw_q <= CW_W'(MAX_CODE_BITS) && nfc_q <= NF_W'(DLIM), "Code table out of range.")
	`GLPD_ASSERT_NOW(a_result_source, $rose(m_tvalid_q), $past(state_q == ST_RESP),
		"Result transfer raised outside the response state.")
endmodule
